### rtl/assert_macros.svh
// Assertion macros used by the checker file of the allocator.
// No dependencies; included by bat_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, no disable condition.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

// Clocked assertion that is switched off while rst is high.
`define ASSERT_CLK_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

### rtl/bat_pkg.sv
// Types and fixed constants of the bump allocator with tail reclaim.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bat_pkg;

   localparam int OFS_W  = 16;   // offsets, tail, region limit
   localparam int SIZE_W = 9;    // entry size in bytes
   localparam int NUM_W  = 6;    // entry number on the result channel
   localparam int STAT_W = 3;
   localparam int FIDX_W = 10;

   localparam logic [SIZE_W-1:0] NUMBER_SIZE = SIZE_W'(4);
   localparam logic [OFS_W-1:0]  LIMIT_RESET = OFS_W'(128);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic KIND_TEXT   = 1'b0;
   localparam logic KIND_NUMBER = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOSPACE = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BADIDX  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FRAG    = 3'd4;

   typedef struct packed {
      logic [OFS_W-1:0]  offset;
      logic [SIZE_W-1:0] size;
      logic              kind;
   } entry_type;

   typedef struct packed {
      logic      ent_we;
      logic      ent_re;
      entry_type ent_wdata;
      logic      mark_we;
      logic      mark_wdata;
      logic      mark_re;
   } mem_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [NUM_W-1:0]  number;
      logic [OFS_W-1:0]  offset;
      logic [OFS_W-1:0]  tail;
      logic              reclaimed;
   } res_type;

endpackage

### rtl/bump_allocator_tail_reclaim.sv
// Top level of the bump allocator with tail reclaim: limit register,
// output register, sequencer and tables. Depends on bat_pkg, bat_store, bat_ctrl.
`timescale 1ns / 1ps

//  channel  ports                        direction  moves
//  req      req_valid / req_stall        in         one allocate or free item
//  rsp      rsp_valid / rsp_stall        out        one result item per request
//  csr      csr_write_enable / _data     in         region limit write
//
//  Steps per item: allocate and out-of-range free go from idle straight to the
//  result; any other free reads the removed mark first. Free of the last live
//  entry above 0 then scans the removed marks downward (one per cycle, single
//  read port) and, when a live entry is found, reads that entry.
//  Reset is synchronous: fill count and tail to 0, limit to 128, no table
//  clearing. A stalled result waits in the output register while the next item is worked on.

module bump_allocator_tail_reclaim #(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_REQUEST = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [8:0]  req_request_size,
   input  logic        req_request_kind,
   input  logic [9:0]  req_free_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_entry_number,
   output logic [15:0] rsp_entry_offset,
   output logic [15:0] rsp_tail_position,
   output logic        rsp_space_reclaimed,

   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import bat_pkg::*;

   // address width of the tables, count width able to hold MAX_ENTRIES itself
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [OFS_W-1:0] limit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff;
   logic             out_free;

   logic          res_valid;
   res_type       res;
   mem_cmd_type   cmd;
   logic [AW-1:0] ent_waddr, ent_raddr, mark_waddr, mark_raddr;
   entry_type     ent_rdata;
   logic          mark_rdata;

   // region limit; software must write it only while the block is idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // output register: free when empty or taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   bat_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_REQUEST (MAX_REQUEST),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_opcode       (req_opcode),
      .req_request_size (req_request_size),
      .req_request_kind (req_request_kind),
      .req_free_index   (req_free_index),
      .req_stall        (req_stall),
      .limit            (limit_ff),
      .out_free         (out_free),
      .res_valid        (res_valid),
      .res              (res),
      .cmd              (cmd),
      .ent_waddr        (ent_waddr),
      .ent_raddr        (ent_raddr),
      .mark_waddr       (mark_waddr),
      .mark_raddr       (mark_raddr),
      .ent_rdata        (ent_rdata),
      .mark_rdata       (mark_rdata)
   );

   bat_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .AW          (AW)
   ) u_store (
      .clock      (clock),
      .cmd        (cmd),
      .ent_waddr  (ent_waddr),
      .ent_raddr  (ent_raddr),
      .mark_waddr (mark_waddr),
      .mark_raddr (mark_raddr),
      .ent_rdata  (ent_rdata),
      .mark_rdata (mark_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_entry_number    = rsp_ff.number;
   assign rsp_entry_offset    = rsp_ff.offset;
   assign rsp_tail_position   = rsp_ff.tail;
   assign rsp_space_reclaimed = rsp_ff.reclaimed;

endmodule

### rtl/bat_store.sv
// Entry table and removed-mark table, both memories with a registered synchronous read.
// Depends on bat_pkg.
`timescale 1ns / 1ps

module bat_store #(
   parameter int MAX_ENTRIES = 64,
   parameter int AW          = 6
) (
   input  logic                clock,
   input  bat_pkg::mem_cmd_type cmd,
   input  logic [AW-1:0]       ent_waddr,
   input  logic [AW-1:0]       ent_raddr,
   input  logic [AW-1:0]       mark_waddr,
   input  logic [AW-1:0]       mark_raddr,
   output bat_pkg::entry_type  ent_rdata,
   output logic                mark_rdata
);
   import bat_pkg::*;

   // Neither table needs clearing: only slots below the fill count are read,
   // and an allocate writes both words of its slot.
   entry_type ent_mem  [MAX_ENTRIES];
   logic      mark_mem [MAX_ENTRIES];

   entry_type ent_rdata_ff;
   logic      mark_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.ent_we) begin
         ent_mem[ent_waddr] <= cmd.ent_wdata;
      end
      if (cmd.ent_re) begin
         ent_rdata_ff <= ent_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_we) begin
         mark_mem[mark_waddr] <= cmd.mark_wdata;
      end
      if (cmd.mark_re) begin
         mark_rdata_ff <= mark_mem[mark_raddr];
      end
   end

   assign ent_rdata  = ent_rdata_ff;
   assign mark_rdata = mark_rdata_ff;

endmodule

### rtl/bat_ctrl.sv
// Sequencer of the allocator: checks, table access, last-live scan, tail update.
// Depends on bat_pkg; drives the memories in bat_store.
`timescale 1ns / 1ps

module bat_ctrl #(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_REQUEST = 256,
   parameter int AW          = 6,
   parameter int CW          = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_opcode,
   input  logic [bat_pkg::SIZE_W-1:0]   req_request_size,
   input  logic                         req_request_kind,
   input  logic [bat_pkg::FIDX_W-1:0]   req_free_index,
   output logic                         req_stall,
   input  logic [bat_pkg::OFS_W-1:0]    limit,
   input  logic                         out_free,
   output logic                         res_valid,
   output bat_pkg::res_type             res,
   output bat_pkg::mem_cmd_type         cmd,
   output logic [AW-1:0]                ent_waddr,
   output logic [AW-1:0]                ent_raddr,
   output logic [AW-1:0]                mark_waddr,
   output logic [AW-1:0]                mark_raddr,
   input  bat_pkg::entry_type           ent_rdata,
   input  logic                         mark_rdata
);
   import bat_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;  // removed mark of the freed entry arrives
   localparam logic [2:0] ST_SCAN = 3'd2;  // walking down for the last live entry
   localparam logic [2:0] ST_END  = 3'd3;  // entry of the new last live arrives
   localparam logic [2:0] ST_SEND = 3'd4;  // result waits for the output register

   logic [2:0]       state_ff, state_in;
   logic [OFS_W-1:0] tail_ff, tail_in;
   logic [CW-1:0]    used_ff, used_in;
   logic [AW-1:0]    last_ff, last_in;
   logic [AW-1:0]    fidx_ff, fidx_in;
   logic [AW-1:0]    scan_ff, scan_in;
   res_type          res_ff, res_in;

   logic [SIZE_W-1:0] size;
   logic [OFS_W:0]    sum;
   logic              no_space;
   logic              full;
   logic              bad_range;
   logic [OFS_W:0]    end_pos;

   // Invariant: the tail always equals the end of the last live entry (or 0).
   // Freeing any other entry therefore leaves the tail where it is.
   always_comb begin
      size      = (req_request_kind == KIND_NUMBER) ? NUMBER_SIZE : req_request_size;
      sum       = {1'b0, tail_ff} + (OFS_W+1)'(size);
      no_space  = (32'(size) > MAX_REQUEST) || (sum > {1'b0, limit});
      full      = 32'(used_ff) >= MAX_ENTRIES;
      bad_range = (32'(req_free_index) >= 32'(used_ff)) ||
                  (32'(req_free_index) >= MAX_ENTRIES);
      end_pos   = {1'b0, ent_rdata.offset} + (OFS_W+1)'(ent_rdata.size);
   end

   always_comb begin
      state_in   = state_ff;
      tail_in    = tail_ff;
      used_in    = used_ff;
      last_in    = last_ff;
      fidx_in    = fidx_ff;
      scan_in    = scan_ff;
      res_in     = res_ff;
      cmd        = '0;
      ent_waddr  = used_ff[AW-1:0];
      ent_raddr  = scan_ff;
      mark_waddr = used_ff[AW-1:0];
      mark_raddr = scan_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               res_in.tail = tail_ff;
               state_in = ST_SEND;
               if (req_opcode == OP_ALLOC) begin
                  priority if (no_space) begin
                     res_in.status = STAT_NOSPACE;
                  end else if (full) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     cmd.ent_we           = 1'b1;
                     cmd.ent_wdata.offset = tail_ff;
                     cmd.ent_wdata.size   = size;
                     cmd.ent_wdata.kind   = req_request_kind;
                     cmd.mark_we          = 1'b1;
                     cmd.mark_wdata       = 1'b0;
                     used_in       = used_ff + CW'(1);
                     tail_in       = sum[OFS_W-1:0];
                     last_in       = used_ff[AW-1:0];
                     res_in.status = STAT_OK;
                     res_in.number = NUM_W'(used_ff[AW-1:0]);
                     res_in.offset = tail_ff;
                     res_in.tail   = sum[OFS_W-1:0];
                  end
               end else if (bad_range) begin
                  res_in.status = STAT_BADIDX;
               end else begin
                  fidx_in     = req_free_index[AW-1:0];
                  cmd.mark_re = 1'b1;
                  mark_raddr  = req_free_index[AW-1:0];
                  state_in    = ST_CHK;
               end
            end
         end

         ST_CHK: begin
            state_in = ST_SEND;
            if (mark_rdata) begin
               res_in.status = STAT_BADIDX;
            end else begin
               // scan reads only addresses below the one written here
               cmd.mark_we    = 1'b1;
               cmd.mark_wdata = 1'b1;
               mark_waddr     = fidx_ff;
               res_in.number  = NUM_W'(fidx_ff);
               priority if (fidx_ff != last_ff) begin
                  res_in.status = STAT_FRAG;
               end else if (fidx_ff == '0) begin
                  tail_in          = '0;
                  res_in.status    = STAT_OK;
                  res_in.tail      = '0;
                  res_in.reclaimed = (tail_ff != '0);
               end else begin
                  cmd.mark_re = 1'b1;
                  mark_raddr  = fidx_ff - AW'(1);
                  scan_in     = fidx_ff - AW'(1);
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            priority if (!mark_rdata) begin
               last_in    = scan_ff;
               cmd.ent_re = 1'b1;
               ent_raddr  = scan_ff;
               state_in   = ST_END;
            end else if (scan_ff == '0) begin
               tail_in          = '0;
               res_in.status    = STAT_OK;
               res_in.tail      = '0;
               res_in.reclaimed = (tail_ff != '0);
               state_in         = ST_SEND;
            end else begin
               cmd.mark_re = 1'b1;
               mark_raddr  = scan_ff - AW'(1);
               scan_in     = scan_ff - AW'(1);
            end
         end

         ST_END: begin
            state_in = ST_SEND;
            if (end_pos < {1'b0, tail_ff}) begin
               tail_in          = end_pos[OFS_W-1:0];
               res_in.status    = STAT_OK;
               res_in.tail      = end_pos[OFS_W-1:0];
               res_in.reclaimed = 1'b1;
            end else begin
               res_in.status = STAT_FRAG;
            end
         end

         ST_SEND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tail_ff  <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      fidx_ff <= fidx_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_SEND);
   assign res       = res_ff;

endmodule

### rtl/bat_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on bat_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [5:0]  rsp_entry_number,
   input logic [15:0] rsp_entry_offset,
   input logic [15:0] rsp_tail_position,
   input logic        rsp_space_reclaimed
);
   import bat_pkg::*;

   logic        rejected;
   logic        req_take;
   logic        rsp_wait;
   logic        rsp_refused;
   logic        no_trace;
   logic        rsp_reclaim;
   logic [41:0] rsp_word;

   assign rejected = (rsp_status == STAT_NOSPACE) || (rsp_status == STAT_FULL) ||
                     (rsp_status == STAT_BADIDX);
   assign req_take    = req_valid && !req_stall;
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_refused = rsp_valid && rejected;
   assign no_trace    = (rsp_entry_number == '0) && (rsp_entry_offset == '0) &&
                        !rsp_space_reclaimed;
   assign rsp_reclaim = rsp_valid && rsp_space_reclaimed;
   assign rsp_word    = {rsp_status, rsp_entry_number, rsp_entry_offset,
                         rsp_tail_position, rsp_space_reclaimed};

   // one item at a time: a taken request closes the input the next cycle
   `ASSERT_CLK_DIS(a_busy_after_accept, clock, reset, req_take |=> req_stall)

   // reset empties the output register
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_valid)

   // a stalled result holds
   `ASSERT_CLK_DIS(a_rsp_hold, clock, reset, rsp_wait |=> (rsp_valid && $stable(rsp_word)))

   // refused items carry no entry and move nothing back
   `ASSERT_CLK_DIS(a_reject_clean, clock, reset, rsp_refused |-> no_trace)

   // reclaim is only reported together with ok status
   `ASSERT_CLK_DIS(a_reclaim_ok, clock, reset, rsp_reclaim |-> (rsp_status == STAT_OK))

endmodule

bind bump_allocator_tail_reclaim bat_checker u_checker (.*);

### sim/testbench.sv
// Self-checking bench for the bump allocator with tail reclaim: a directed table,
// then paced random allocate/free traffic over a dozen region limit settings.
// Depends on bat_pkg and bump_allocator_tail_reclaim.
`timescale 1ns / 1ps

module testbench;
   import bat_pkg::*;

   localparam int MAX_ENT  = 64;
   localparam int MAX_REQ  = 256;
   localparam int N_PHASES = 12;
   localparam int N_RANDOM = 1628;

   // One row of directed stimulus; want is only used when typed is set.
   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] size;
      logic              kind;
      logic [FIDX_W-1:0] index;
      logic              typed;
      res_type           want;
   } stim_row_type;

   // Opening sequence at the reset limit of 128 bytes. Typed rows: behavior
   // straight after reset, region overflow, oversize and bad index.
   localparam stim_row_type DIRECTED_ROWS [0:22] = '{
      // zero-length entry, then free it while the tail is already 0
      '{OP_ALLOC, 9'd0,   KIND_TEXT,   10'd0,    1'b1, '{STAT_OK,      6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd0,    1'b1, '{STAT_OK,      6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd0,    1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd1023, 1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      // one byte past the region, then past the largest request
      '{OP_ALLOC, 9'd129, KIND_TEXT,   10'd0,    1'b1, '{STAT_NOSPACE, 6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_ALLOC, 9'd511, KIND_TEXT,   10'd1023, 1'b1, '{STAT_NOSPACE, 6'd0, 16'd0, 16'd0,   1'b0}},
      // number kind ignores the size field; then fill the region exactly
      '{OP_ALLOC, 9'd257, KIND_NUMBER, 10'd0,    1'b0, '0},
      '{OP_ALLOC, 9'd124, KIND_TEXT,   10'd0,    1'b0, '0},
      '{OP_ALLOC, 9'd0,   KIND_NUMBER, 10'd0,    1'b1, '{STAT_NOSPACE, 6'd0, 16'd0, 16'd128, 1'b0}},
      '{OP_ALLOC, 9'd0,   KIND_TEXT,   10'd0,    1'b0, '0},
      // middle entry freed, then ends equal to the tail: tail stays
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd1,    1'b0, '0},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd3,    1'b0, '0},
      // last live entry gone: tail back to 0
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd2,    1'b0, '0},
      '{OP_ALLOC, 9'd256, KIND_TEXT,   10'd0,    1'b1, '{STAT_NOSPACE, 6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_ALLOC, 9'd100, KIND_TEXT,   10'd0,    1'b0, '0},
      '{OP_ALLOC, 9'd20,  KIND_TEXT,   10'd0,    1'b0, '0},
      // top entry freed: tail drops to the end of the one below
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd5,    1'b0, '0},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd4,    1'b0, '0},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd4,    1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd6,    1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd63,   1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_FREE,  9'd0,   KIND_TEXT,   10'd512,  1'b1, '{STAT_BADIDX,  6'd0, 16'd0, 16'd0,   1'b0}},
      '{OP_ALLOC, 9'd128, KIND_TEXT,   10'd0,    1'b0, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_ALLOC;
   logic [8:0]  req_request_size = '0;
   logic        req_request_kind = KIND_TEXT;
   logic [9:0]  req_free_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_entry_number;
   logic [15:0] rsp_entry_offset;
   logic [15:0] rsp_tail_position;
   logic        rsp_space_reclaimed;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   // Predicted allocator state
   logic [OFS_W-1:0]  ent_offset  [MAX_ENT];
   logic [SIZE_W-1:0] ent_size    [MAX_ENT];
   logic              ent_kind    [MAX_ENT];
   bit                ent_removed [MAX_ENT];
   int                used_count;
   logic [OFS_W-1:0]  tail_now;
   logic [OFS_W-1:0]  limit_now;

   res_type pending_results [$];     // outcomes owed by the block, oldest first

   int mismatch_count  = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int limit_writes    = 0;
   int reclaim_count   = 0;
   int status_count [8];

   // Knobs shared by the sender, the receiver and the stimulus
   bit gaps_on      = 1'b1;
   bit stalls_on    = 1'b1;
   bit hold_request = 1'b0;

   bump_allocator_tail_reclaim #(
      .MAX_ENTRIES(MAX_ENT),
      .MAX_REQUEST(MAX_REQ)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_request_size   (req_request_size),
      .req_request_kind   (req_request_kind),
      .req_free_index     (req_free_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_entry_number   (rsp_entry_number),
      .rsp_entry_offset   (rsp_entry_offset),
      .rsp_tail_position  (rsp_tail_position),
      .rsp_space_reclaimed(rsp_space_reclaimed),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // Idle length: mostly short, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Outcome of one item; updates the predicted tables, tail and fill count
   function automatic res_type allocator_outcome(input logic op,
                                                  input logic [SIZE_W-1:0] req_size,
                                                  input logic kd,
                                                  input logic [FIDX_W-1:0] fi);
      res_type r;
      logic [SIZE_W-1:0] nbytes;
      int last_live;
      int end_pos;
      r = '0;
      r.status = STAT_OK;
      if (op == OP_ALLOC) begin
         nbytes = (kd == KIND_NUMBER) ? NUMBER_SIZE : req_size;
         // space is checked before table capacity
         if (int'(nbytes) > MAX_REQ || int'(tail_now) + int'(nbytes) > int'(limit_now)) begin
            r.status = STAT_NOSPACE;
         end else if (used_count >= MAX_ENT) begin
            r.status = STAT_FULL;
         end else begin
            ent_offset[used_count]  = tail_now;
            ent_size[used_count]    = nbytes;
            ent_kind[used_count]    = kd;
            ent_removed[used_count] = 1'b0;
            r.number = NUM_W'(used_count);
            r.offset = tail_now;
            tail_now = tail_now + OFS_W'(nbytes);
            used_count++;
         end
      end else if (int'(fi) >= used_count || ent_removed[fi]) begin
         r.status = STAT_BADIDX;
      end else begin
         ent_removed[fi] = 1'b1;
         r.number = NUM_W'(fi);
         last_live = -1;
         for (int e = used_count - 1; e >= 0 && last_live < 0; e--) begin
            if (!ent_removed[e]) last_live = e;
         end
         if (last_live < 0) begin
            r.reclaimed = (tail_now != '0);
            tail_now = '0;
         end else begin
            end_pos = int'(ent_offset[last_live]) + int'(ent_size[last_live]);
            if (end_pos < int'(tail_now)) begin
               tail_now = OFS_W'(end_pos);
               r.reclaimed = 1'b1;
            end else begin
               r.status = STAT_FRAG;
            end
         end
      end
      r.tail = tail_now;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got_val, input int want_val);
      $display("mismatch in %s at result %0d: got %0d, want %0d",
               field, results_checked, got_val, want_val);
      mismatch_count++;
   endtask

   // Offer one item at a falling edge and hold it until taken. Returns at the
   // falling edge after acceptance with valid still high, so back-to-back
   // items never lower and raise valid in one step.
   task automatic offer_item(input logic op, input logic [SIZE_W-1:0] sz, input logic kd,
                             input logic [FIDX_W-1:0] fi, input logic typed,
                             input res_type typed_res);
      int gap;
      res_type predicted;
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) < 25) gap = idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_request_size <= sz;
      req_request_kind <= kd;
      req_free_index   <= fi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = allocator_outcome(op, sz, kd, fi);
      pending_results.push_back(typed ? typed_res : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering, wait for every owed result, then let the block settle
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Limit writes happen only with the block idle
   task automatic set_region_limit(input logic [OFS_W-1:0] value);
      drain_results(4);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      limit_now = value;
      limit_writes++;
   endtask

   // Receiver: random stalls, plus one long hold on request that lets the
   // block back up into its input while the sender keeps offering.
   initial begin : result_receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 150;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Checker: every accepted result against the oldest owed outcome
   always @(posedge clock) begin : result_check
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing owed, status", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_entry_number !== want.number)
               report_mismatch("entry_number", rsp_entry_number, want.number);
            if (rsp_entry_offset !== want.offset)
               report_mismatch("entry_offset", rsp_entry_offset, want.offset);
            if (rsp_tail_position !== want.tail)
               report_mismatch("tail_position", rsp_tail_position, want.tail);
            if (rsp_space_reclaimed !== want.reclaimed)
               report_mismatch("space_reclaimed", rsp_space_reclaimed, want.reclaimed);
            status_count[want.status]++;
            if (want.reclaimed) reclaim_count++;
         end
         results_checked++;
      end
   end

   // Main stimulus
   initial begin : stimulus
      int per_phase;
      int step;
      int roll;
      int room;
      int pick;
      int limit_pick;
      logic op;
      logic [SIZE_W-1:0] sz;
      logic kd;
      logic [FIDX_W-1:0] fi;
      int live_list [$];

      // predictor reset state
      used_count = 0;
      tail_now   = '0;
      limit_now  = LIMIT_RESET;
      for (int e = 0; e < MAX_ENT; e++) ent_removed[e] = 1'b0;
      for (int s = 0; s < 8; s++) status_count[s] = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r])
         offer_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].size, DIRECTED_ROWS[r].kind,
                    DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      per_phase = N_RANDOM / N_PHASES;
      step = 0;
      for (int p = 0; p < N_PHASES; p++) begin
         // limit per phase: 1 and the maximum first, then a rotation of
         // tight room, maximum, below the tail and anything at all
         if (p == 0) limit_pick = 1;
         else if (p == 1) limit_pick = 65535;
         else begin
            case (p % 4)
               0: begin
                  limit_pick = int'(tail_now) + $urandom_range(1, 300);
                  if (limit_pick > 65535) limit_pick = 65535;
               end
               1: limit_pick = 65535;
               2: limit_pick = (tail_now > 1) ? $urandom_range(1, int'(tail_now) - 1) : 1;
               default: limit_pick = $urandom_range(1, 65535);
            endcase
         end
         set_region_limit(OFS_W'(limit_pick));

         // some phases run with no gaps or no stalls at all
         gaps_on   = (p % 3 != 1) && (p != 3);
         stalls_on = (p % 3 != 2);
         if (p == 3) hold_request = 1'b1;

         for (int k = 0; k < per_phase; k++) begin
            if (p == 6 && k == per_phase / 2) drain_results(0);

            live_list.delete();
            for (int e = 0; e < used_count; e++)
               if (!ent_removed[e]) live_list.push_back(e);

            op = OP_FREE;
            sz = SIZE_W'($urandom);
            kd = KIND_TEXT;
            fi = FIDX_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               op = OP_ALLOC;
               // pace the 64 table slots over the whole random part
               if (used_count < 6 + (60 * step) / N_RANDOM ||
                   (used_count >= MAX_ENT && $urandom_range(0, 1))) begin
                  pick = $urandom_range(0, 9);
                  if (pick == 0) sz = '0;
                  else if (pick < 3) kd = KIND_NUMBER;
                  else sz = SIZE_W'($urandom_range(1, 24));
               end else begin
                  // a request that cannot fit
                  room = int'(limit_now) - int'(tail_now);
                  if (room >= 0 && room < 511 && $urandom_range(0, 1))
                     sz = SIZE_W'($urandom_range(room + 1, 511));
                  else
                     sz = SIZE_W'($urandom_range(257, 511));
               end
            end else if (roll < 88) begin
               // free a live entry more often the more there are
               if (live_list.size() != 0 && $urandom_range(0, 7) < live_list.size())
                  fi = FIDX_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
               else
                  fi = FIDX_W'($urandom_range(0, used_count + 2));
            end else begin
               op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
               kd = $urandom_range(0, 1) ? KIND_NUMBER : KIND_TEXT;
            end
            offer_item(op, sz, kd, fi, 1'b0, '0);
            step++;
         end
      end

      drain_results(80);

      $display("covered %0d items and %0d limit writes: ok %0d, no space %0d, table full %0d,",
               items_sent, limit_writes, status_count[STAT_OK], status_count[STAT_NOSPACE],
               status_count[STAT_FULL]);
      $display("bad index %0d, fragmented %0d, tail pulled back %0d times, %0d results checked",
               status_count[STAT_BADIDX], status_count[STAT_FRAG], reclaim_count,
               results_checked);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bat_pkg.sv
rtl/bat_store.sv
rtl/bat_ctrl.sv
rtl/bump_allocator_tail_reclaim.sv
rtl/bat_checker.sv
sim/testbench.sv
